FILE: src/gcf_pkg.sv
// shared types, codes, constants and arithmetic helpers for the gru cell step
package gcf_pkg;

  localparam int HIDDEN_DIM_DEF = 16;
  localparam int INPUT_DIM_DEF  = 16;
  localparam int FRAC_BITS_DEF  = 12;

  localparam logic [2:0] OP_WEIGHT  = 3'd0;
  localparam logic [2:0] OP_BIAS    = 3'd1;
  localparam logic [2:0] OP_INPUT   = 3'd2;
  localparam logic [2:0] OP_HIDDEN  = 3'd3;
  localparam logic [2:0] OP_COMPUTE = 3'd4;

  localparam logic CFG_IDX_BIAS = 1'b0;
  localparam logic CFG_IDX_CTX  = 1'b1;

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] EXP_M1_32 = 64'd1040706261;
  localparam logic [63:0] EXP_M1_16 = 64'd1008687096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XRUN,
    S_HRUN,
    S_FIN,
    S_WAIT,
    S_DRAIN
  } state_t;

  // element token moving down the cell row
  typedef struct packed {
    logic vld;
    logic fin;
    logic ph;
  } tok_t;

  // load bus broadcast to every cell
  typedef struct packed {
    logic [2:0]         wx_we;
    logic [2:0]         wh_we;
    logic [2:0]         b_we;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] val;
  } ld_t;

  // e^(-(2k+1)/32) in q30, elaboration only
  function automatic logic [63:0] exp_pow(input int k);
    logic [63:0] e;
    e = EXP_M1_32;
    for (int i = 0; i < k; i++) begin
      e = (e * EXP_M1_16 + (Q30_ONE >> 1)) >> 30;
    end
    return e;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] a);
    logic signed [15:0] r;
    if (a > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (a < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = a[15:0];
    end
    return r;
  endfunction

  // add half, floor shift, saturate
  function automatic logic signed [15:0] rsat(input logic signed [47:0] a, input int frac);
    logic signed [47:0] t;
    t = (a + (48'sd1 <<< (frac - 1))) >>> frac;
    return sat16(t);
  endfunction

  // table bin for a q value, clamped to the table
  function automatic logic [7:0] lut_bin(input logic signed [15:0] v, input int sh);
    logic signed [16:0] b;
    logic [7:0] r;
    b = 17'(v >>> sh) + 17'sd128;
    if (b < 17'sd0) begin
      r = 8'd0;
    end else if (b > 17'sd255) begin
      r = 8'd255;
    end else begin
      r = b[7:0];
    end
    return r;
  endfunction

endpackage

FILE: src/gcf_act.sv
// sigmoid and tanh lookup tables, two sigmoid reads and one tanh read
module gcf_act
  import gcf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic signed [15:0] z_sum,
  input  logic signed [15:0] r_sum,
  input  logic signed [15:0] c_sum,
  output logic signed [15:0] z_sig,
  output logic signed [15:0] r_sig,
  output logic signed [15:0] c_tanh
);

  localparam int SH = FRAC_BITS - 4;

  logic signed [15:0] sig_tab  [256];
  logic signed [15:0] tanh_tab [256];

  for (genvar k = 0; k < 128; k++) begin : g_tab
    localparam logic [63:0] E    = exp_pow(k);
    localparam logic [63:0] E2   = (E * E + (Q30_ONE >> 1)) >> 30;
    localparam logic [63:0] DEN  = Q30_ONE + E;
    localparam logic [63:0] SP   = ((Q30_ONE << FRAC_BITS) + DEN / 2) / DEN;
    localparam logic [63:0] DEN2 = Q30_ONE + E2;
    localparam logic [63:0] TP   = (((Q30_ONE - E2) << FRAC_BITS) + DEN2 / 2) / DEN2;
    assign sig_tab[128 + k]  = 16'(SP);
    assign sig_tab[127 - k]  = 16'((64'd1 << FRAC_BITS) - SP);
    assign tanh_tab[128 + k] = 16'(TP);
    assign tanh_tab[127 - k] = -16'(TP);
  end

  assign z_sig  = sig_tab[lut_bin(z_sum, SH)];
  assign r_sig  = sig_tab[lut_bin(r_sum, SH)];
  assign c_tanh = tanh_tab[lut_bin(c_sum, SH)];

endmodule

FILE: src/gcf_cell.sv
// one hidden unit: weight rows, three macs, gate finish and result shift stage
module gcf_cell
  import gcf_pkg::*;
#(
  parameter int HIDDEN_DIM = HIDDEN_DIM_DEF,
  parameter int INPUT_DIM  = INPUT_DIM_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int INDEX      = 0,
  parameter int IW         = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               use_bias,
  input  ld_t                ld,
  input  tok_t               tok_i,
  input  logic [IW-1:0]      idx_i,
  input  logic signed [15:0] val_i,
  output tok_t               tok_o,
  output logic [IW-1:0]      idx_o,
  output logic signed [15:0] val_o,
  input  logic               shift,
  input  logic signed [15:0] res_i,
  output logic signed [15:0] res_o,
  output logic               done_o
);

  localparam int XA_W  = (INPUT_DIM > 1) ? $clog2(INPUT_DIM) : 1;
  localparam int HA_W  = $clog2(HIDDEN_DIM);
  localparam int ACC_W = 32 + $clog2(INPUT_DIM + HIDDEN_DIM + 1);

  logic signed [15:0] wx_mem [3][INPUT_DIM];
  logic signed [15:0] wh_mem [3][HIDDEN_DIM];
  logic signed [15:0] wx_rd_r [3];
  logic signed [15:0] wh_rd_r [3];
  logic signed [15:0] b_r [3];

  tok_t               tok_r;
  logic [IW-1:0]      idx_r;
  logic signed [15:0] val_r;

  logic signed [31:0] p_r [3];
  logic               pv_r, pph_r, pfirst_r;
  logic               f1_r, f2_r, f3_r, f4_r, f5_r;

  logic signed [ACC_W-1:0] acc_z_r, acc_r_r, acc_cx_r, acc_ch_r;
  logic signed [15:0] h_r, z_r, r_r, rh_r, c_r, res_r;
  logic signed [31:0] m_r;
  logic signed [32:0] pz_r;

  logic               row_hit;
  logic signed [47:0] bias_z, bias_r, bias_c;
  logic signed [15:0] z_sum, r_sum, c_sum, z_sig, r_sig, c_tanh;
  logic signed [16:0] diff;
  logic signed [47:0] hn_sum;

  assign row_hit = (8'(ld.row) == 8'(INDEX));

  // weight rows of this unit, read at the token's element index
  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      if (row_hit && ld.wx_we[g]) begin
        wx_mem[g][XA_W'(ld.col)] <= ld.val;
      end
      if (row_hit && ld.wh_we[g]) begin
        wh_mem[g][HA_W'(ld.col)] <= ld.val;
      end
      if (row_hit && ld.b_we[g]) begin
        b_r[g] <= ld.val;
      end
      wx_rd_r[g] <= wx_mem[g][idx_i[XA_W-1:0]];
      wh_rd_r[g] <= wh_mem[g][idx_i[HA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      pv_r  <= 1'b0;
      f1_r  <= 1'b0;
      f2_r  <= 1'b0;
      f3_r  <= 1'b0;
      f4_r  <= 1'b0;
      f5_r  <= 1'b0;
    end else begin
      tok_r <= tok_i;
      pv_r  <= tok_r.vld;
      f1_r  <= tok_r.fin;
      f2_r  <= f1_r;
      f3_r  <= f2_r;
      f4_r  <= f3_r;
      f5_r  <= f4_r;
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;
  assign val_o = val_r;

  assign bias_z = use_bias ? (48'(b_r[0]) <<< FRAC_BITS) : '0;
  assign bias_r = use_bias ? (48'(b_r[1]) <<< FRAC_BITS) : '0;
  assign bias_c = use_bias ? (48'(b_r[2]) <<< FRAC_BITS) : '0;

  assign z_sum  = rsat(48'(acc_z_r) + bias_z, FRAC_BITS);
  assign r_sum  = rsat(48'(acc_r_r) + bias_r, FRAC_BITS);
  assign c_sum  = rsat(48'(m_r) + 48'(acc_cx_r) + bias_c, FRAC_BITS);
  assign diff   = 17'(h_r) - 17'(c_r);
  assign hn_sum = ((48'(pz_r) + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + 48'(c_r);

  gcf_act #(.FRAC_BITS(FRAC_BITS)) u_act (
    .z_sum  (z_sum),
    .r_sum  (r_sum),
    .c_sum  (c_sum),
    .z_sig  (z_sig),
    .r_sig  (r_sig),
    .c_tanh (c_tanh)
  );

  always_ff @(posedge clk) begin
    idx_r <= idx_i;
    val_r <= val_i;
    // products: x weights in the first phase, h weights in the second
    for (int g = 0; g < 3; g++) begin
      p_r[g] <= (tok_r.ph ? wh_rd_r[g] : wx_rd_r[g]) * val_r;
    end
    pph_r    <= tok_r.ph;
    pfirst_r <= (idx_r == '0);
    if (tok_r.vld && tok_r.ph && (idx_r == IW'(INDEX))) begin
      h_r <= val_r;
    end
    // first x element restarts acc_z, acc_r and acc_cx; first h element acc_ch
    if (pv_r) begin
      acc_z_r <= ((pfirst_r && !pph_r) ? '0 : acc_z_r) + ACC_W'(p_r[0]);
      acc_r_r <= ((pfirst_r && !pph_r) ? '0 : acc_r_r) + ACC_W'(p_r[1]);
      if (!pph_r) begin
        acc_cx_r <= (pfirst_r ? '0 : acc_cx_r) + ACC_W'(p_r[2]);
      end else begin
        acc_ch_r <= (pfirst_r ? '0 : acc_ch_r) + ACC_W'(p_r[2]);
      end
    end
    if (f1_r) begin
      z_r  <= z_sig;
      r_r  <= r_sig;
      rh_r <= rsat(48'(acc_ch_r), FRAC_BITS);
    end
    if (f2_r) begin
      m_r <= r_r * rh_r;
    end
    if (f3_r) begin
      c_r <= c_tanh;
    end
    if (f4_r) begin
      pz_r <= z_r * diff;
    end
    if (f5_r) begin
      res_r <= sat16(hn_sum);
    end else if (shift) begin
      res_r <= res_i;
    end
  end

  assign res_o  = res_r;
  assign done_o = f5_r;

endmodule

FILE: src/gru_cell_forward_step.sv
// gated recurrent unit forward step: loads, element sequencer, cell row, result port
//
// Load items (weights, biases, input and previous hidden elements) are taken one per
// cycle while idle. A compute item streams the INPUT_DIM input elements and then the
// HIDDEN_DIM hidden elements down a row of HIDDEN_DIM cells, one element per cycle;
// each cell owns one hidden unit and runs three 16x16 multiply-accumulates on every
// element that passes. After the stream each cell finishes its gates in five steps
// and the results shift out through cell 0, hidden unit 0 first, last flag on the
// final one. With a ready result port, the length of a compute is set by the element
// stream, the hop through the cell row and the result shift. New items are held off
// until the last result has entered the output register.
module gru_cell_forward_step
  import gcf_pkg::*;
#(
  parameter int HIDDEN_DIM = HIDDEN_DIM_DEF,
  parameter int INPUT_DIM  = INPUT_DIM_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row_index[3:0], col_index[7:4], value[23:8]
  input  logic [5:0]  in_tuser,   // opcode[2:0], matrix_select[5:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // hidden_value[15:0], hidden_index[19:16], zeros
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAXD = (INPUT_DIM > HIDDEN_DIM) ? INPUT_DIM : HIDDEN_DIM;
  localparam int IW   = $clog2(MAXD);
  localparam int XA_W = (INPUT_DIM > 1) ? $clog2(INPUT_DIM) : 1;
  localparam int HA_W = $clog2(HIDDEN_DIM);

  state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic use_bias_r, use_ctx_r;

  logic signed [15:0] x_mem [INPUT_DIM];
  logic signed [15:0] h_mem [HIDDEN_DIM];
  logic [HIDDEN_DIM-1:0] h_vld_r;
  logic signed [15:0] xrd_r, hrd_r;
  logic hv_r;

  tok_t pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;

  logic out_valid_r;
  logic signed [15:0] out_val_r;
  logic [3:0] out_idx_r;
  logic out_last_r;

  logic [2:0] op, sel;
  logic [3:0] row, col;
  logic signed [15:0] val;
  logic in_acc, row_ok, colx_ok, colh_ok, shift, out_load, cfg_wr;
  ld_t  ld;

  tok_t               tok_w [HIDDEN_DIM+1];
  logic [IW-1:0]      idx_w [HIDDEN_DIM+1];
  logic signed [15:0] val_w [HIDDEN_DIM+1];
  logic signed [15:0] res_w [HIDDEN_DIM+1];
  logic [HIDDEN_DIM-1:0] done_w;

  assign op      = in_tuser[2:0];
  assign sel     = in_tuser[5:3];
  assign row     = in_tdata[3:0];
  assign col     = in_tdata[7:4];
  assign val     = in_tdata[23:8];
  assign in_acc  = in_tvalid && in_tready;
  assign row_ok  = 9'(row) < 9'(HIDDEN_DIM);
  assign colx_ok = 9'(col) < 9'(INPUT_DIM);
  assign colh_ok = 9'(col) < 9'(HIDDEN_DIM);

  always_comb begin
    ld     = '0;
    ld.row = row;
    ld.col = col;
    ld.val = val;
    for (int g = 0; g < 3; g++) begin
      ld.wx_we[g] = in_acc && (op == OP_WEIGHT) && (sel == 3'(g)) && row_ok && colx_ok;
      ld.wh_we[g] = in_acc && (op == OP_WEIGHT) && (sel == 3'(g + 3)) && row_ok && colh_ok;
      ld.b_we[g]  = in_acc && (op == OP_BIAS) && (sel == 3'(g)) && row_ok;
    end
  end

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_bias_r <= 1'b0;
      use_ctx_r  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_IDX_BIAS: use_bias_r <= cfg_pwdata[0];
        CFG_IDX_CTX:  use_ctx_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_IDX_BIAS: cfg_prdata = {31'd0, use_bias_r};
      CFG_IDX_CTX:  cfg_prdata = {31'd0, use_ctx_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // element stores; previous hidden entries read as zero until written
  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_INPUT) && colx_ok) begin
      x_mem[XA_W'(col)] <= val;
    end
    if (in_acc && (op == OP_HIDDEN) && colh_ok) begin
      h_mem[HA_W'(col)] <= val;
    end
    xrd_r <= x_mem[cnt_r[XA_W-1:0]];
    hrd_r <= h_mem[cnt_r[HA_W-1:0]];
    hv_r  <= h_vld_r[cnt_r[HA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= '0;
    end else if (in_acc && (op == OP_HIDDEN) && colh_ok) begin
      h_vld_r[HA_W'(col)] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      pend_r     <= '0;
      pend_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      pend_idx_r <= pend_idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = '0;
    pend_idx_nxt = cnt_r;
    in_tready    = 1'b0;
    shift        = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cnt_nxt   = '0;
        if (in_tvalid && (op == OP_COMPUTE)) begin
          state_nxt = S_XRUN;
        end
      end
      S_XRUN: begin
        pend_nxt.vld = 1'b1;
        if (cnt_r == IW'(INPUT_DIM - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_HRUN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_HRUN: begin
        pend_nxt.vld = 1'b1;
        pend_nxt.ph  = 1'b1;
        if (cnt_r == IW'(HIDDEN_DIM - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        pend_nxt.fin = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (done_w[HIDDEN_DIM-1]) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        out_load = !out_valid_r || out_tready;
        shift    = out_load;
        if (out_load) begin
          if (cnt_r == IW'(HIDDEN_DIM - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell row
  assign tok_w[0] = pend_r;
  assign idx_w[0] = pend_idx_r;
  assign val_w[0] = pend_r.ph ? ((use_ctx_r && hv_r) ? hrd_r : 16'sd0) : xrd_r;
  assign res_w[HIDDEN_DIM] = '0;

  for (genvar j = 0; j < HIDDEN_DIM; j++) begin : g_cell
    gcf_cell #(
      .HIDDEN_DIM (HIDDEN_DIM),
      .INPUT_DIM  (INPUT_DIM),
      .FRAC_BITS  (FRAC_BITS),
      .INDEX      (j),
      .IW         (IW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .use_bias (use_bias_r),
      .ld       (ld),
      .tok_i    (tok_w[j]),
      .idx_i    (idx_w[j]),
      .val_i    (val_w[j]),
      .tok_o    (tok_w[j+1]),
      .idx_o    (idx_w[j+1]),
      .val_o    (val_w[j+1]),
      .shift    (shift),
      .res_i    (res_w[j+1]),
      .res_o    (res_w[j]),
      .done_o   (done_w[j])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r  <= res_w[0];
      out_idx_r  <= 4'(cnt_r);
      out_last_r <= (cnt_r == IW'(HIDDEN_DIM - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_idx_r, out_val_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: src/gcf_checker.sv
// port checker for the gru cell step, bound to the top level
module gcf_checker
  import gcf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [5:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[2:0] == OP_COMPUTE) |=> !in_tready)
    else $error("input taken during a compute");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("config port not ready");

endmodule

bind gru_cell_forward_step gcf_checker u_gcf_checker (.*);
